// File: sv/aat_pkg.sv
// ---------------------------------------------------------------------------
// aat_pkg
// Shared constants, payload types and pipeline control for the activity
// throttle trigger.
// ---------------------------------------------------------------------------
`default_nettype none

package aat_pkg;

  localparam int BLOCK_LEN = 400;
  localparam int HISTORY   = 10;

  localparam int SAMPLE_W = 16;
  localparam int DEV_W    = 15;
  localparam int DEV_MAX  = 32767;
  localparam int THR_W    = 15;
  localparam int RUN_W    = 8;
  localparam int BLANK_W  = 4;

  // block sum and divider sizing
  localparam int MAG_W    = $clog2(BLOCK_LEN * 32768 + 1);
  localparam int SUM_W    = MAG_W + 1;
  localparam int CNT_W    = $clog2(BLOCK_LEN + 1);
  localparam int RECIP_SH = MAG_W + $clog2(BLOCK_LEN);
  localparam longint unsigned RECIP =
    ((64'd1 << RECIP_SH) + 64'(BLOCK_LEN) - 64'd1) / 64'(BLOCK_LEN);
  localparam int QUO_W    = SAMPLE_W + 1;
  localparam int PROD_W   = RECIP_SH + QUO_W;

  // deviation adder tree
  localparam int DIFF_W = SAMPLE_W;
  localparam int PAIRS  = (HISTORY + 1) / 2;
  localparam int PAIR_W = DIFF_W + 1;
  localparam int ACC_W  = PAIR_W + $clog2(PAIRS + 1);

  // configuration port
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_UP_THRESHOLD    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_QUIET_LIMIT_X   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_QUIET_LIMIT_Y   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_QUIET_LIMIT_Z   = 8'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UP_RUNS_NEEDED  = 8'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CUT_RUNS_NEEDED = 8'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BLANK_BLOCKS    = 8'd6;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] accel_x;
    logic signed [SAMPLE_W-1:0] accel_y;
    logic signed [SAMPLE_W-1:0] accel_z;
  } sample_t;

  typedef struct packed {
    logic             block_done;
    logic [DEV_W-1:0] dev_x;
    logic [DEV_W-1:0] dev_y;
    logic [DEV_W-1:0] dev_z;
    logic             raise_pulse;
    logic             lower_pulse;
    logic             blanking;
  } result_t;

  typedef struct packed {
    logic accept;
    logic block_end;
    logic load_b;
    logic shift;
    logic load_c;
    logic load_d;
  } pipe_ctrl_t;

endpackage

`default_nettype wire

// File: sv/aat_if.sv
// ---------------------------------------------------------------------------
// aat channel interfaces
// Valid/ready channels for samples, results and configuration writes.
// ---------------------------------------------------------------------------
`default_nettype none

interface aat_sample_if;
  logic             valid;
  logic             ready;
  aat_pkg::sample_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface aat_result_if;
  logic             valid;
  logic             ready;
  aat_pkg::result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface aat_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [aat_pkg::CFG_IDX_W-1:0]     index;
  logic [aat_pkg::CFG_DATA_W-1:0]    data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: sv/aat_axis_avg.sv
// ---------------------------------------------------------------------------
// aat_axis_avg
// One axis: running block sum, then block average by reciprocal multiply
// (truncating toward zero).
// ---------------------------------------------------------------------------
`default_nettype none

module aat_axis_avg (
  input  logic                                 clk,
  input  logic                                 rst,
  input  aat_pkg::pipe_ctrl_t                  ctrl,
  input  logic signed [aat_pkg::SAMPLE_W-1:0]  sample_in,
  output logic signed [aat_pkg::SAMPLE_W-1:0]  avg
);

  logic signed [aat_pkg::SUM_W-1:0] sum;
  logic signed [aat_pkg::SUM_W-1:0] sum_next;
  logic signed [aat_pkg::SUM_W-1:0] total;
  logic [aat_pkg::MAG_W-1:0]        mag;
  logic [aat_pkg::PROD_W-1:0]       prod;
  logic [aat_pkg::QUO_W-1:0]        quo;
  logic [aat_pkg::QUO_W-1:0]        quo_signed;

  assign sum_next   = sum + aat_pkg::SUM_W'(sample_in);
  assign mag        = total[aat_pkg::SUM_W-1] ? aat_pkg::MAG_W'(-total)
                                              : aat_pkg::MAG_W'(total);
  assign prod       = aat_pkg::PROD_W'(mag) * aat_pkg::PROD_W'(aat_pkg::RECIP);
  assign quo        = prod[aat_pkg::RECIP_SH +: aat_pkg::QUO_W];
  assign quo_signed = total[aat_pkg::SUM_W-1] ? -quo : quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
    end else if (ctrl.accept) begin
      sum <= ctrl.block_end ? '0 : sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.accept && ctrl.block_end) begin
      total <= sum_next;
    end
    if (ctrl.load_b) begin
      avg <= quo_signed[aat_pkg::SAMPLE_W-1:0];
    end
  end

endmodule

`default_nettype wire

// File: sv/aat_axis_dev.sv
// ---------------------------------------------------------------------------
// aat_axis_dev
// One axis: history window of past averages, absolute deviation sum over a
// two-level registered adder tree, saturation.
// ---------------------------------------------------------------------------
`default_nettype none

module aat_axis_dev (
  input  logic                                 clk,
  input  logic                                 rst,
  input  aat_pkg::pipe_ctrl_t                  ctrl,
  input  logic signed [aat_pkg::SAMPLE_W-1:0]  avg,
  output logic [aat_pkg::DEV_W-1:0]            dev
);

  logic signed [aat_pkg::SAMPLE_W-1:0] hist [aat_pkg::HISTORY];
  logic [aat_pkg::DIFF_W-1:0]          absd [aat_pkg::HISTORY];
  logic [aat_pkg::PAIR_W-1:0]          pair_next [aat_pkg::PAIRS];
  logic [aat_pkg::PAIR_W-1:0]          pair [aat_pkg::PAIRS];
  logic [aat_pkg::ACC_W-1:0]           acc;

  for (genvar i = 0; i < aat_pkg::HISTORY; i++) begin : g_diff
    logic signed [aat_pkg::SAMPLE_W:0] d;
    assign d       = (aat_pkg::SAMPLE_W + 1)'(avg) - (aat_pkg::SAMPLE_W + 1)'(hist[i]);
    assign absd[i] = d[aat_pkg::SAMPLE_W] ? aat_pkg::DIFF_W'(-d) : aat_pkg::DIFF_W'(d);
  end

  for (genvar p = 0; p < aat_pkg::PAIRS; p++) begin : g_pair
    if (2 * p + 1 < aat_pkg::HISTORY) begin : g_two
      assign pair_next[p] = aat_pkg::PAIR_W'(absd[2*p]) + aat_pkg::PAIR_W'(absd[2*p+1]);
    end else begin : g_one
      assign pair_next[p] = aat_pkg::PAIR_W'(absd[2*p]);
    end
  end

  always_comb begin
    acc = '0;
    for (int p = 0; p < aat_pkg::PAIRS; p++) begin
      acc = acc + aat_pkg::ACC_W'(pair[p]);
    end
  end

  // window shift, oldest entry at index zero
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < aat_pkg::HISTORY; i++) begin
        hist[i] <= '0;
      end
    end else if (ctrl.shift) begin
      for (int i = 0; i < aat_pkg::HISTORY - 1; i++) begin
        hist[i] <= hist[i+1];
      end
      hist[aat_pkg::HISTORY-1] <= avg;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_c) begin
      for (int p = 0; p < aat_pkg::PAIRS; p++) begin
        pair[p] <= pair_next[p];
      end
    end
    if (ctrl.load_d) begin
      dev <= (acc > aat_pkg::ACC_W'(aat_pkg::DEV_MAX)) ? aat_pkg::DEV_W'(aat_pkg::DEV_MAX)
                                                       : acc[aat_pkg::DEV_W-1:0];
    end
  end

endmodule

`default_nettype wire

// File: sv/accel_activity_throttle_trigger_core.sv
// ---------------------------------------------------------------------------
// accel_activity_throttle_trigger_core
// Three-axis activity detector: block averages, deviation against a history
// window, and speed-up / speed-cut trigger decisions.
// ---------------------------------------------------------------------------
// Accepts one sample per clock while the result side keeps up, and returns one
// result per sample, in order. Each sample passes through five register stages
// (block sum, average, pair deviations, saturated deviation, decision/output
// register) before its result is presented. Every BLOCK_LEN samples the average
// is formed by a reciprocal multiply and compared against the last HISTORY
// averages; the trigger state is updated only in the final stage, one block
// at a time.
// Configuration writes are accepted in any cycle and should be made while no
// sample is in flight.
`default_nettype none

module accel_activity_throttle_trigger_core (
  input  logic        clk,
  input  logic        rst,
  aat_sample_if.sink  sample,
  aat_result_if.source result,
  aat_cfg_if.sink     cfg
);

  // configuration registers
  logic [aat_pkg::THR_W-1:0]   up_threshold;
  logic [aat_pkg::THR_W-1:0]   quiet_limit_x;
  logic [aat_pkg::THR_W-1:0]   quiet_limit_y;
  logic [aat_pkg::THR_W-1:0]   quiet_limit_z;
  logic [aat_pkg::RUN_W-1:0]   up_runs_needed;
  logic [aat_pkg::RUN_W-1:0]   cut_runs_needed;
  logic [aat_pkg::BLANK_W-1:0] blank_blocks;

  // pipeline control
  logic                        sample_count_end;
  logic [aat_pkg::CNT_W-1:0]   sample_count;
  logic                        a_valid, b_valid, c_valid, d_valid, out_valid;
  logic                        a_done, b_done, c_done, d_done;
  logic                        load_a, load_b, load_c, load_d, load_out;
  logic                        fire;
  aat_pkg::pipe_ctrl_t         ctrl;

  logic signed [aat_pkg::SAMPLE_W-1:0] avg_x, avg_y, avg_z;
  logic [aat_pkg::DEV_W-1:0]           dev_x, dev_y, dev_z;

  // trigger state
  logic [aat_pkg::RUN_W-1:0]   up_run, up_run_next;
  logic [aat_pkg::RUN_W-1:0]   cut_run, cut_run_next;
  logic                        up_lock, up_lock_next;
  logic                        cut_lock, cut_lock_next;
  logic [aat_pkg::BLANK_W-1:0] blank_left, blank_left_next;
  aat_pkg::result_t            result_next;
  aat_pkg::result_t            result_reg;

  logic [aat_pkg::RUN_W-1:0]   upn, cutn;
  logic [aat_pkg::RUN_W-1:0]   up_inc, cut_inc;
  logic                        active, quiet;

  // handshakes
  assign load_out     = !out_valid || result.ready;
  assign load_d       = !d_valid || load_out;
  assign load_c       = !c_valid || load_d;
  assign load_b       = !b_valid || load_c;
  assign load_a       = !a_valid || load_b;
  assign sample.ready = load_a;
  assign fire         = load_out && d_valid;

  assign result.valid = out_valid;
  assign result.data  = result_reg;
  assign cfg.ready    = 1'b1;

  assign sample_count_end = (sample_count == aat_pkg::CNT_W'(aat_pkg::BLOCK_LEN - 1));

  always_comb begin
    ctrl           = '0;
    ctrl.accept    = sample.valid && load_a;
    ctrl.block_end = sample_count_end;
    ctrl.load_b    = load_b;
    ctrl.shift     = load_c && b_valid && b_done;
    ctrl.load_c    = load_c;
    ctrl.load_d    = load_d;
  end

  aat_axis_avg u_avg_x (.clk(clk), .rst(rst), .ctrl(ctrl),
                        .sample_in(sample.data.accel_x), .avg(avg_x));
  aat_axis_avg u_avg_y (.clk(clk), .rst(rst), .ctrl(ctrl),
                        .sample_in(sample.data.accel_y), .avg(avg_y));
  aat_axis_avg u_avg_z (.clk(clk), .rst(rst), .ctrl(ctrl),
                        .sample_in(sample.data.accel_z), .avg(avg_z));

  aat_axis_dev u_dev_x (.clk(clk), .rst(rst), .ctrl(ctrl), .avg(avg_x), .dev(dev_x));
  aat_axis_dev u_dev_y (.clk(clk), .rst(rst), .ctrl(ctrl), .avg(avg_y), .dev(dev_y));
  aat_axis_dev u_dev_z (.clk(clk), .rst(rst), .ctrl(ctrl), .avg(avg_z), .dev(dev_z));

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      up_threshold    <= aat_pkg::THR_W'(160);
      quiet_limit_x   <= aat_pkg::THR_W'(150);
      quiet_limit_y   <= aat_pkg::THR_W'(150);
      quiet_limit_z   <= aat_pkg::THR_W'(500);
      up_runs_needed  <= aat_pkg::RUN_W'(3);
      cut_runs_needed <= aat_pkg::RUN_W'(4);
      blank_blocks    <= aat_pkg::BLANK_W'(12);
    end else if (cfg.valid) begin
      case (cfg.index)
        aat_pkg::REG_UP_THRESHOLD:    up_threshold    <= cfg.data[aat_pkg::THR_W-1:0];
        aat_pkg::REG_QUIET_LIMIT_X:   quiet_limit_x   <= cfg.data[aat_pkg::THR_W-1:0];
        aat_pkg::REG_QUIET_LIMIT_Y:   quiet_limit_y   <= cfg.data[aat_pkg::THR_W-1:0];
        aat_pkg::REG_QUIET_LIMIT_Z:   quiet_limit_z   <= cfg.data[aat_pkg::THR_W-1:0];
        aat_pkg::REG_UP_RUNS_NEEDED:  up_runs_needed  <= cfg.data[aat_pkg::RUN_W-1:0];
        aat_pkg::REG_CUT_RUNS_NEEDED: cut_runs_needed <= cfg.data[aat_pkg::RUN_W-1:0];
        aat_pkg::REG_BLANK_BLOCKS:    blank_blocks    <= cfg.data[aat_pkg::BLANK_W-1:0];
        default: ;
      endcase
    end
  end

  // sample counter and stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= '0;
      a_valid      <= 1'b0;
      b_valid      <= 1'b0;
      c_valid      <= 1'b0;
      d_valid      <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (ctrl.accept) begin
        sample_count <= sample_count_end ? '0 : sample_count + 1'b1;
      end
      if (load_a)   a_valid   <= sample.valid;
      if (load_b)   b_valid   <= a_valid;
      if (load_c)   c_valid   <= b_valid;
      if (load_d)   d_valid   <= c_valid;
      if (load_out) out_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_a) a_done <= sample_count_end;
    if (load_b) b_done <= a_done;
    if (load_c) c_done <= b_done;
    if (load_d) d_done <= c_done;
    if (fire)   result_reg <= result_next;
  end

  // decision
  assign upn     = (up_runs_needed == '0) ? aat_pkg::RUN_W'(1) : up_runs_needed;
  assign cutn    = (cut_runs_needed == '0) ? aat_pkg::RUN_W'(1) : cut_runs_needed;
  assign up_inc  = (up_run == '1) ? up_run : up_run + 1'b1;
  assign cut_inc = (cut_run == '1) ? cut_run : cut_run + 1'b1;
  assign active  = dev_x > up_threshold;
  assign quiet   = (dev_x < quiet_limit_x) && (dev_y < quiet_limit_y) &&
                   (dev_z < quiet_limit_z) && up_lock;

  always_comb begin
    up_run_next     = up_run;
    cut_run_next    = cut_run;
    up_lock_next    = up_lock;
    cut_lock_next   = cut_lock;
    blank_left_next = blank_left;

    result_next             = '0;
    result_next.block_done  = d_done;
    result_next.blanking    = (blank_left != '0);

    if (d_done) begin
      result_next.dev_x = dev_x;
      result_next.dev_y = dev_y;
      result_next.dev_z = dev_z;
      if (blank_left != '0) begin
        blank_left_next = blank_left - 1'b1;
      end else begin
        up_run_next = active ? up_inc : '0;
        if (quiet) begin
          cut_run_next = cut_inc;
          up_run_next  = '0;
        end else begin
          cut_run_next = '0;
        end
        if ((up_run_next == upn) && !up_lock) begin
          result_next.raise_pulse = 1'b1;
          up_lock_next            = 1'b1;
          cut_lock_next           = 1'b0;
          up_run_next             = '0;
        end
        if ((cut_run_next == cutn) && !cut_lock_next) begin
          result_next.lower_pulse = 1'b1;
          blank_left_next         = blank_blocks;
          cut_run_next            = '0;
          cut_lock_next           = 1'b1;
          up_lock_next            = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      up_run     <= '0;
      cut_run    <= '0;
      up_lock    <= 1'b0;
      cut_lock   <= 1'b0;
      blank_left <= '0;
    end else if (fire) begin
      up_run     <= up_run_next;
      cut_run    <= cut_run_next;
      up_lock    <= up_lock_next;
      cut_lock   <= cut_lock_next;
      blank_left <= blank_left_next;
    end
  end

endmodule

`default_nettype wire

// File: tb/aat_throttle_tracker_pkg.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// aat_throttle_tracker_pkg
// Tracks the activity throttle trigger from the samples the core accepts:
// block sums, block averages, the per-axis history windows, run counters,
// locks and blanking. Each accepted sample yields one predicted result,
// which is compared field by field with the next result the core returns.
// ---------------------------------------------------------------------------
package aat_throttle_tracker_pkg;
  import aat_pkg::*;

  localparam int RUN_SAT = (1 << RUN_W) - 1;

  class throttle_tracker;
    logic [THR_W-1:0]   up_threshold;
    logic [THR_W-1:0]   quiet_x;
    logic [THR_W-1:0]   quiet_y;
    logic [THR_W-1:0]   quiet_z;
    logic [RUN_W-1:0]   up_needed;
    logic [RUN_W-1:0]   cut_needed;
    logic [BLANK_W-1:0] blank_blocks;

    longint  axis_sum[3];
    int      sample_cnt;
    int      window[3][HISTORY];
    int      up_run;
    int      cut_run;
    bit      up_lock;
    bit      cut_lock;
    int      blank_left;
    result_t trigger_results_q[$];
    int      results_seen;
    int      mismatches;

    function new();
      up_threshold = 160;
      quiet_x      = 150;
      quiet_y      = 150;
      quiet_z      = 500;
      up_needed    = 3;
      cut_needed   = 4;
      blank_blocks = 12;
      for (int a = 0; a < 3; a++) begin
        axis_sum[a] = 0;
        for (int i = 0; i < HISTORY; i++) window[a][i] = 0;
      end
      sample_cnt   = 0;
      up_run       = 0;
      cut_run      = 0;
      up_lock      = 1'b0;
      cut_lock     = 1'b0;
      blank_left   = 0;
      results_seen = 0;
      mismatches   = 0;
    endfunction

    function void apply_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_UP_THRESHOLD:    up_threshold = value[THR_W-1:0];
        REG_QUIET_LIMIT_X:   quiet_x      = value[THR_W-1:0];
        REG_QUIET_LIMIT_Y:   quiet_y      = value[THR_W-1:0];
        REG_QUIET_LIMIT_Z:   quiet_z      = value[THR_W-1:0];
        REG_UP_RUNS_NEEDED:  up_needed    = value[RUN_W-1:0];
        REG_CUT_RUNS_NEEDED: cut_needed   = value[RUN_W-1:0];
        REG_BLANK_BLOCKS:    blank_blocks = value[BLANK_W-1:0];
        default: ;
      endcase
    endfunction

    function void take_sample(sample_t s);
      result_t          r;
      int               avg;
      int               acc;
      int               diff;
      int               upn;
      int               cutn;
      bit               active;
      bit               quiet;
      logic [DEV_W-1:0] dev[3];
      r = '0;
      r.blanking = (blank_left != 0);
      axis_sum[0] += longint'($signed(s.accel_x));
      axis_sum[1] += longint'($signed(s.accel_y));
      axis_sum[2] += longint'($signed(s.accel_z));
      sample_cnt++;
      if (sample_cnt >= BLOCK_LEN) begin
        r.block_done = 1'b1;
        sample_cnt = 0;
        for (int a = 0; a < 3; a++) begin
          // signed division truncates toward zero
          avg = int'(axis_sum[a] / BLOCK_LEN);
          axis_sum[a] = 0;
          acc = 0;
          for (int i = 0; i < HISTORY; i++) begin
            diff = avg - window[a][i];
            acc += (diff < 0) ? -diff : diff;
          end
          for (int i = 0; i + 1 < HISTORY; i++) window[a][i] = window[a][i + 1];
          window[a][HISTORY - 1] = avg;
          dev[a] = (acc > DEV_MAX) ? DEV_W'(DEV_MAX) : DEV_W'(acc);
        end
        r.dev_x = dev[0];
        r.dev_y = dev[1];
        r.dev_z = dev[2];
        if (blank_left != 0) begin
          blank_left--;
        end else begin
          upn    = (up_needed == 0) ? 1 : int'(up_needed);
          cutn   = (cut_needed == 0) ? 1 : int'(cut_needed);
          active = dev[0] > up_threshold;
          quiet  = dev[0] < quiet_x && dev[1] < quiet_y && dev[2] < quiet_z && up_lock;
          up_run = active ? ((up_run >= RUN_SAT) ? RUN_SAT : up_run + 1) : 0;
          if (quiet) begin
            cut_run = (cut_run >= RUN_SAT) ? RUN_SAT : cut_run + 1;
            up_run  = 0;
          end else begin
            cut_run = 0;
          end
          if (up_run == upn && !up_lock) begin
            r.raise_pulse = 1'b1;
            up_lock  = 1'b1;
            cut_lock = 1'b0;
            up_run   = 0;
          end
          if (cut_run == cutn && !cut_lock) begin
            r.lower_pulse = 1'b1;
            blank_left = int'(blank_blocks);
            cut_run    = 0;
            cut_lock   = 1'b1;
            up_lock    = 1'b0;
          end
        end
      end
      trigger_results_q.push_back(r);
    endfunction

    function void match_result(result_t got);
      result_t want;
      results_seen++;
      if (trigger_results_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result %0d arrived with no request outstanding", $time,
                   results_seen);
        return;
      end
      want = trigger_results_q.pop_front();
      if (got.block_done !== want.block_done || got.dev_x !== want.dev_x ||
          got.dev_y !== want.dev_y || got.dev_z !== want.dev_z ||
          got.raise_pulse !== want.raise_pulse || got.lower_pulse !== want.lower_pulse ||
          got.blanking !== want.blanking) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: result %0d mismatch", $time, results_seen);
          $display("  expected done=%0b dev=%0d/%0d/%0d raise=%0b lower=%0b blank=%0b",
                   want.block_done, want.dev_x, want.dev_y, want.dev_z,
                   want.raise_pulse, want.lower_pulse, want.blanking);
          $display("  actual   done=%0b dev=%0d/%0d/%0d raise=%0b lower=%0b blank=%0b",
                   got.block_done, got.dev_x, got.dev_y, got.dev_z,
                   got.raise_pulse, got.lower_pulse, got.blanking);
        end
      end
    endfunction

    function int outstanding();
      return trigger_results_q.size();
    endfunction
  endclass

endpackage

// File: tb/accel_activity_throttle_trigger_core_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// accel_activity_throttle_trigger_core_test
// Drives 400-sample blocks of three-axis samples into the core, built
// from steady levels, level shifts, full-range noise and rail values, across
// a few register settings (reset values, hair trigger, random). Both sides
// idle at random, the result side holds off once long enough to stall the
// input, and every result is checked against the tracker's prediction.
// ---------------------------------------------------------------------------
module accel_activity_throttle_trigger_core_test;
  import aat_pkg::*;
  import aat_throttle_tracker_pkg::*;

  localparam int HALF_PERIOD   = 6;
  localparam int RESET_CYCLES  = 9;
  localparam int MAX_GAP       = 17;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 12;
  localparam int STALL_LIMIT   = 4000;
  localparam int PART_SAMPLES  = 250;
  localparam int SAMPLE_MAX    = 32767;
  localparam int SAMPLE_MIN    = -32768;
  localparam int N_CORNERS     = 12;
  localparam int CORNERS[N_CORNERS] = '{32767, -32768, 0, -1, 1, 21845, -21846,
                                        256, -256, 127, -32767, 16384};
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 8'd7;

  typedef enum int {IDLE_NONE, IDLE_SPARSE, IDLE_FULL} idle_mode_e;
  typedef enum int {LVL_STEADY, LVL_SHIFT, LVL_RAW, LVL_RAIL} level_kind_e;

  logic clk = 1'b0;
  logic rst = 1'b1;

  aat_sample_if sample_ch();
  aat_result_if result_ch();
  aat_cfg_if    cfg_ch();

  accel_activity_throttle_trigger_core u_dut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  throttle_tracker tracker = new();
  idle_mode_e      send_idle = IDLE_NONE;
  idle_mode_e      recv_idle = IDLE_NONE;
  bit              hold_req = 1'b0;
  int              blk_pos = 0;
  int              level[3] = '{0, 0, 0};
  int              stall_cycles = 0;

  always #HALF_PERIOD clk = ~clk;

  function automatic int idle_gap(input idle_mode_e mode);
    case (mode)
      IDLE_FULL:   return int'($urandom_range(0, MAX_GAP));
      IDLE_SPARSE: return ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, MAX_GAP)) : 0;
      default:     return 0;
    endcase
  endfunction

  function automatic int clamp16(input int v);
    return (v > SAMPLE_MAX) ? SAMPLE_MAX : (v < SAMPLE_MIN) ? SAMPLE_MIN : v;
  endfunction

  function automatic level_kind_e pick_kind();
    int r;
    r = int'($urandom_range(0, 99));
    if (r < 50) return LVL_STEADY;
    if (r < 86) return LVL_SHIFT;
    if (r < 93) return LVL_RAW;
    return LVL_RAIL;
  endfunction

  // accepted requests, results and register writes; stall watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (sample_ch.valid && sample_ch.ready) tracker.take_sample(sample_ch.data);
      if (result_ch.valid && result_ch.ready) tracker.match_result(result_ch.data);
      if (cfg_ch.valid && cfg_ch.ready) tracker.apply_write(cfg_ch.index, cfg_ch.data);
      if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("accel_activity_throttle_trigger_core_test: errors");
          $finish;
        end
      end
    end
  end

  // result side
  initial begin : result_side
    int gap;
    result_ch.ready = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (hold_req) begin
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      gap = idle_gap(recv_idle);
      if (gap > 0) begin
        result_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!result_ch.valid);
      @(negedge clk);
    end
  end

  task automatic send_sample(input sample_t s);
    int gap;
    gap = idle_gap(send_idle);
    if (gap > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    sample_ch.valid <= 1'b1;
    sample_ch.data  <= s;
    do @(posedge clk); while (!sample_ch.ready);
    @(negedge clk);
    blk_pos = (blk_pos + 1) % BLOCK_LEN;
  endtask

  // count of zero runs to the end of the current block
  task automatic send_block(input level_kind_e kind, input int count);
    int      n;
    int      noise;
    int      span;
    int      v[3];
    sample_t s;
    n = BLOCK_LEN - blk_pos;
    if (count > 0 && count < n) n = count;
    for (int a = 0; a < 3; a++) begin
      if (kind == LVL_SHIFT) begin
        case ($urandom_range(0, 2))
          0:       span = 40;
          1:       span = 600;
          default: span = 30000;
        endcase
        level[a] = clamp16(level[a] + int'($urandom_range(0, 2 * span)) - span);
      end else if (kind == LVL_RAIL) begin
        level[a] = $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
      end
    end
    noise = (kind == LVL_RAIL) ? 0 : int'($urandom_range(0, 12));
    repeat (n) begin
      for (int a = 0; a < 3; a++) begin
        if (kind == LVL_RAW)
          v[a] = int'($signed(16'($urandom)));
        else
          v[a] = clamp16(level[a] + int'($urandom_range(0, 2 * noise)) - noise);
      end
      s.accel_x = 16'(v[0]);
      s.accel_y = 16'(v[1]);
      s.accel_z = 16'(v[2]);
      send_sample(s);
    end
  endtask

  // wait until every request has its result, then let the pipeline settle
  task automatic drain();
    sample_ch.valid <= 1'b0;
    while (tracker.outstanding() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic run_phase(input int blocks, input idle_mode_e si, input idle_mode_e ri);
    send_idle = si;
    recv_idle = ri;
    repeat (blocks) send_block(pick_kind(), 0);
    drain();
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
  endtask

  task automatic load_settings(input logic [CFG_DATA_W-1:0] thr, qx, qy, qz,
                               input logic [CFG_DATA_W-1:0] upn, cutn, blank);
    cfg_write(REG_UP_THRESHOLD, thr);
    cfg_write(REG_QUIET_LIMIT_X, qx);
    cfg_write(REG_QUIET_LIMIT_Y, qy);
    cfg_write(REG_QUIET_LIMIT_Z, qz);
    cfg_write(REG_UP_RUNS_NEEDED, upn);
    cfg_write(REG_CUT_RUNS_NEEDED, cutn);
    cfg_write(REG_BLANK_BLOCKS, blank);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic load_random_settings();
    load_settings({1'($urandom), 15'($urandom_range(0, 2000))},
                  {1'($urandom), 15'($urandom_range(0, 6000))},
                  {1'($urandom), 15'($urandom_range(0, 6000))},
                  {1'($urandom), 15'($urandom_range(0, 9000))},
                  {8'($urandom), 8'($urandom_range(0, 4))},
                  {8'($urandom), 8'($urandom_range(0, 5))},
                  16'($urandom));
  endtask

  initial begin : stimulus
    sample_t s;
    sample_ch.valid = 1'b0;
    sample_ch.data  = '0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = '0;
    cfg_ch.data     = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // field extremes and bit patterns inside the first block
    send_idle = IDLE_NONE;
    recv_idle = IDLE_SPARSE;
    for (int i = 0; i < N_CORNERS; i++) begin
      s.accel_x = 16'(CORNERS[i]);
      s.accel_y = 16'(CORNERS[(i + 3) % N_CORNERS]);
      s.accel_z = 16'(CORNERS[(i + 7) % N_CORNERS]);
      send_sample(s);
    end

    // reset settings
    run_phase(1, IDLE_FULL, IDLE_FULL);

    // hair trigger with zero run requirement and no blanking, while the
    // result side holds off for a long stretch and requests keep coming
    load_settings(16'd0, 16'h7fff, 16'h7fff, 16'h7fff, 16'd0, 16'd1, 16'd0);
    cfg_write(REG_SPARE, 16'hffff);
    cfg_ch.valid <= 1'b0;
    hold_req = 1'b1;
    run_phase(1, IDLE_NONE, IDLE_NONE);

    // random settings over part of a block
    load_random_settings();
    send_idle = IDLE_FULL;
    recv_idle = IDLE_SPARSE;
    send_block(pick_kind(), PART_SAMPLES);
    drain();

    if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
      $display("accel_activity_throttle_trigger_core_test: clean");
    end else begin
      $display("accel_activity_throttle_trigger_core_test: errors");
    end
    $finish;
  end

endmodule
